### sv/bcr_pkg.sv
// bcr_pkg: types, codes and constants of the bus command receiver
// shared by bcr_ctrl, bcr_datapath and bus_command_receiver_unit; no dependencies
`default_nettype none

package bcr_pkg;

    localparam int NUM_FUNCTIONS = 7;
    localparam int NUM_CHANNELS  = 16;
    localparam int CNT_W         = (NUM_FUNCTIONS > 1) ? $clog2(NUM_FUNCTIONS) : 1;

    localparam logic [7:0] CMD_ACK    = 8'h00;
    localparam logic [7:0] CMD_PING   = 8'h01;
    localparam logic [7:0] CMD_CFG_A  = 8'hFE;
    localparam logic [7:0] CMD_CFG_B  = 8'hFC;
    localparam logic [7:0] CMD_BOOT   = 8'hFF;
    localparam logic [7:0] BCAST_MASK = 8'hE0;
    localparam logic [7:0] CHR_B      = 8'h42;
    localparam logic [7:0] CHR_L      = 8'h4C;
    localparam logic [3:0] FN_LED_ON  = 4'd2;
    localparam logic [3:0] FN_LED_OFF = 4'd3;

    typedef enum logic [2:0] {
        ACT_START   = 3'd0,
        ACT_BYTE    = 3'd1,
        ACT_END     = 3'd2,
        ACT_SENT    = 3'd3,
        ACT_TIMEOUT = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        LS_IDLE = 2'd0,
        LS_ACK  = 2'd1,
        LS_CFG  = 2'd2
    } t_link;

    typedef enum logic [1:0] {
        MSG_NONE  = 2'd0,
        MSG_PING  = 2'd1,
        MSG_STATE = 2'd2
    } t_msg;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] packet_address;
        logic       packet_toggle;
        logic [7:0] packet_length;
        logic [7:0] byte_position;
        logic [7:0] payload_byte;
        logic       crc_ok;
        logic       repeated;
    } t_in_item;

    typedef struct packed {
        logic        reboot;
        logic [1:0]  message_kind;
        logic        message_toggle;
        logic        ack_done;
        logic        nack;
        logic        cancel_timer;
        logic        config_entry;
        logic [3:0]  function_index;
        logic [15:0] channel_mask;
        logic [15:0] led_mask;
        logic        send_toggle;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic take;
        logic step;
    } t_ctl_cmd;

    typedef struct packed {
        logic yields;
        logic last;
    } t_dp_status;

    function automatic logic is_cfg_cmd(input logic [7:0] c);
        return (c == CMD_CFG_A) || (c == CMD_CFG_B);
    endfunction

endpackage

`default_nettype wire

### sv/bcr_ctrl.sv
// bcr_ctrl: handshake controller, accepts items and sequences the result transfers
// depends on bcr_pkg
`default_nettype none

module bcr_ctrl
    import bcr_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    input  t_dp_status  i_status,
    output t_ctl_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.take = 1'b0;
        o_cmd.step = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_status.yields) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (!i_out_stall) begin
                    o_cmd.step = !i_status.last;
                    if (i_status.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

endmodule

`default_nettype wire

### sv/bcr_datapath.sv
// bcr_datapath: receive state, packet decode, staged enable table and result fields
// depends on bcr_pkg; driven by bcr_ctrl commands
`default_nettype none

module bcr_datapath
    import bcr_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [7:0]  i_cfg_data,
    input  t_in_item    i_item,
    input  t_ctl_cmd    i_cmd,
    output t_dp_status  o_status,
    output t_out_item   o_out_item
);

    logic [7:0]              r_module_address;
    logic                    r_listening, n_listening;
    logic [7:0]              r_rx_address, n_rx_address;
    logic                    r_rx_toggle, n_rx_toggle;
    logic [7:0]              r_command_byte, n_command_byte;
    logic                    r_boot_cand, n_boot_cand;
    logic [7:0]              r_rx_length, n_rx_length;
    logic [NUM_CHANNELS-1:0] r_pend [NUM_FUNCTIONS];
    logic [NUM_CHANNELS-1:0] n_pend [NUM_FUNCTIONS];
    t_link                   r_link, n_link;
    logic                    r_tx_toggle, n_tx_toggle;
    logic [NUM_CHANNELS-1:0] r_leds, n_leds;
    logic [CNT_W-1:0]        r_cnt, n_cnt;

    // result descriptor of the item under transfer
    logic                    r_reboot, n_reboot;
    t_msg                    r_kind, n_kind;
    logic                    r_ack, n_ack;
    logic                    r_nack, n_nack;
    logic                    r_cancel, n_cancel;
    logic                    r_apply, n_apply;
    logic                    r_msg_tog, n_msg_tog;

    logic                    yields;
    logic                    boot;
    logic [3:0]              fn_sel;
    logic [3:0]              st_fn;
    logic [3:0]              st_ch;
    logic [7:0]              hdr_len;
    logic                    bcast;

    assign bcast   = (r_rx_address & BCAST_MASK) == BCAST_MASK;
    assign hdr_len = (r_command_byte == CMD_CFG_B) ? 8'd4 : 8'd3;
    assign st_fn   = i_item.payload_byte[3:0];
    assign st_ch   = i_item.payload_byte[7:4];

    always_comb begin
        n_listening    = r_listening;
        n_rx_address   = r_rx_address;
        n_rx_toggle    = r_rx_toggle;
        n_command_byte = r_command_byte;
        n_boot_cand    = r_boot_cand;
        n_rx_length    = r_rx_length;
        n_pend         = r_pend;
        n_link         = r_link;
        n_tx_toggle    = r_tx_toggle;
        n_leds         = r_leds;
        n_reboot       = 1'b0;
        n_kind         = MSG_NONE;
        n_ack          = 1'b0;
        n_nack         = 1'b0;
        n_cancel       = 1'b0;
        n_apply        = 1'b0;
        boot           = 1'b0;
        fn_sel         = 4'd0;
        yields         = 1'b0;
        case (i_item.action)
            ACT_START: begin
                n_rx_address = i_item.packet_address;
                n_rx_toggle  = i_item.packet_toggle;
                n_listening  = (i_item.packet_address == r_module_address)
                            || ((i_item.packet_address & BCAST_MASK) == BCAST_MASK);
                n_boot_cand  = (i_item.packet_length == 8'd3);
                n_rx_length  = i_item.packet_length;
            end
            ACT_BYTE: begin
                if (r_listening) begin
                    if (i_item.byte_position == 8'd0) begin
                        n_command_byte = i_item.payload_byte;
                        if (i_item.payload_byte != CMD_PING) begin
                            n_boot_cand = 1'b0;
                        end
                        if (is_cfg_cmd(i_item.payload_byte)) begin
                            for (int j = 0; j < NUM_FUNCTIONS; j++) begin
                                n_pend[j] = '0;
                            end
                        end
                    end else begin
                        if ((i_item.byte_position == 8'd1 && i_item.payload_byte != CHR_B)
                         || (i_item.byte_position == 8'd2 && i_item.payload_byte != CHR_L)) begin
                            n_boot_cand = 1'b0;
                        end
                        if (is_cfg_cmd(r_command_byte) && (i_item.byte_position > hdr_len)
                         && ({1'b0, st_ch} < 5'(NUM_CHANNELS))) begin
                            for (int j = 0; j < NUM_FUNCTIONS; j++) begin
                                if (st_fn == 4'(j)) begin
                                    n_pend[j] = r_pend[j]
                                              | (NUM_CHANNELS'(1) << st_ch);
                                end
                            end
                        end
                    end
                end
            end
            ACT_SENT: begin
                yields = 1'b1;
                n_link = LS_ACK;
            end
            ACT_TIMEOUT: begin
                yields = 1'b1;
                n_nack = (r_link == LS_ACK);
            end
            ACT_END: begin
                yields = 1'b1;
                if (r_listening && i_item.crc_ok) begin
                    if (bcast) begin
                        boot = (r_command_byte == CMD_BOOT);
                    end else if (r_boot_cand) begin
                        boot = 1'b1;
                    end else if (r_command_byte == CMD_ACK) begin
                        if (r_link == LS_ACK) begin
                            n_link      = LS_IDLE;
                            n_tx_toggle = !r_tx_toggle;
                            n_cancel    = 1'b1;
                            n_ack       = 1'b1;
                        end
                    end else if (r_command_byte == CMD_PING) begin
                        n_kind = MSG_PING;
                    end else if (is_cfg_cmd(r_command_byte)) begin
                        n_apply = 1'b1;
                        if (r_link == LS_CFG) begin
                            n_link   = LS_IDLE;
                            n_cancel = 1'b1;
                        end
                    end else if (r_command_byte == CMD_BOOT) begin
                        boot = (r_rx_length == 8'd1);
                    end else begin
                        fn_sel = r_command_byte[3:0];
                        if (i_item.repeated) begin
                            fn_sel = 4'd0;
                            n_kind = MSG_STATE;
                        end
                        if (fn_sel == FN_LED_ON) begin
                            n_leds = ({1'b0, r_command_byte[7:4]} < 5'(NUM_CHANNELS))
                                   ? (NUM_CHANNELS'(1) << r_command_byte[7:4]) : '0;
                            n_kind = MSG_STATE;
                        end else if (fn_sel == FN_LED_OFF) begin
                            n_leds = '0;
                            n_kind = MSG_STATE;
                        end
                    end
                    if (boot) begin
                        n_reboot    = 1'b1;
                        n_kind      = MSG_NONE;
                        n_ack       = 1'b0;
                        n_cancel    = 1'b0;
                        n_apply     = 1'b0;
                        n_link      = r_link;
                        n_tx_toggle = r_tx_toggle;
                        n_leds      = r_leds;
                    end else if (n_link == LS_ACK) begin
                        n_link   = LS_IDLE;
                        n_nack   = 1'b1;
                        n_cancel = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        n_msg_tog = (n_kind != MSG_NONE) ? r_rx_toggle : 1'b0;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.take) begin
            n_cnt = '0;
        end else if (i_cmd.step) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_module_address <= '0;
            r_listening      <= 1'b0;
            r_rx_address     <= '0;
            r_rx_toggle      <= 1'b0;
            r_command_byte   <= '0;
            r_boot_cand      <= 1'b0;
            r_rx_length      <= '0;
            for (int j = 0; j < NUM_FUNCTIONS; j++) begin
                r_pend[j] <= '0;
            end
            r_link           <= LS_CFG;
            r_tx_toggle      <= 1'b0;
            r_leds           <= '0;
            r_cnt            <= '0;
        end else begin
            if (i_cfg_we) begin
                r_module_address <= i_cfg_data;
            end
            if (i_cmd.take) begin
                r_listening    <= n_listening;
                r_rx_address   <= n_rx_address;
                r_rx_toggle    <= n_rx_toggle;
                r_command_byte <= n_command_byte;
                r_boot_cand    <= n_boot_cand;
                r_rx_length    <= n_rx_length;
                r_pend         <= n_pend;
                r_link         <= n_link;
                r_tx_toggle    <= n_tx_toggle;
                r_leds         <= n_leds;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_reboot  <= n_reboot;
            r_kind    <= n_kind;
            r_msg_tog <= n_msg_tog;
            r_ack     <= n_ack;
            r_nack    <= n_nack;
            r_cancel  <= n_cancel;
            r_apply   <= n_apply;
        end
    end

    logic out_last;
    assign out_last = !r_apply || (r_cnt == CNT_W'(NUM_FUNCTIONS - 1));

    assign o_status.yields = yields;
    assign o_status.last   = out_last;

    always_comb begin
        o_out_item                = '0;
        o_out_item.reboot         = r_reboot;
        o_out_item.led_mask       = 16'(r_leds);
        o_out_item.send_toggle    = r_tx_toggle;
        o_out_item.last           = out_last;
        if (r_apply) begin
            o_out_item.config_entry   = 1'b1;
            o_out_item.function_index = 4'(r_cnt);
            o_out_item.channel_mask   = 16'(r_pend[r_cnt]);
        end
        if (out_last) begin
            o_out_item.message_kind   = r_kind;
            o_out_item.message_toggle = r_msg_tog;
            o_out_item.ack_done       = r_ack;
            o_out_item.nack           = r_nack;
            o_out_item.cancel_timer   = r_cancel;
        end
    end

endmodule

`default_nettype wire

### sv/bus_command_receiver_unit.sv
// bus_command_receiver_unit: top level of the bus command receiver
// depends on bcr_pkg, bcr_ctrl and bcr_datapath
//
//   channel   signals                         direction
//   in        i_in_valid o_in_stall i_in_data  item in (t_in_item)
//   out       o_out_valid i_out_stall o_out_data  result out (t_out_item)
//   cfg       i_cfg_we i_cfg_data              module address write
//
// packet start, payload byte and unknown items give no result and are taken back to back
// packet end, event sent and timeout give one or more result transfers before the next item is taken
// a config apply gives NUM_FUNCTIONS transfers, read from the staged table by a counter
// the input stalls while results are pending; reset is synchronous and needs no clearing pass
`default_nettype none

module bus_command_receiver_unit
    import bcr_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [7:0] i_cfg_data,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output t_out_item  o_out_data
);

    t_ctl_cmd   cmd;
    t_dp_status status;

    bcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bcr_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_item (o_out_data)
    );

    a_no_accept_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while results pending");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.last) |=> !o_out_valid)
        else $error("results continue after last transfer");

    a_multi_is_config: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last) |-> o_out_data.config_entry)
        else $error("non-final result without table entry");

    a_reboot_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.reboot) |->
            (o_out_data.last && !o_out_data.config_entry && !o_out_data.nack))
        else $error("reboot result carries other flags");

    a_entry_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.config_entry) |->
            ({1'b0, o_out_data.function_index} < 5'(NUM_FUNCTIONS)))
        else $error("table entry index out of range");

endmodule

`default_nettype wire

### dv/bus_command_receiver_unit_tb.sv
// bus_command_receiver_unit_tb: self-checking testbench for the bus command receiver
// runs directed and random packet traffic, predicts every result transfer and checks it
// depends on bcr_pkg and bus_command_receiver_unit
`default_nettype none

module bus_command_receiver_unit_tb
    import bcr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RESET_CYCLES  = 7;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          HOLD_CYCLES   = 150;
    localparam int          LIMIT_CYCLES  = 400000;
    localparam int          CFG_A_HEADER  = 3;
    localparam int          CFG_B_HEADER  = 4;
    localparam logic [2:0]  ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0]  ACT_UNUSED_HI = 3'd7;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_data;

    bus_command_receiver_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // receiver state as predicted
    logic [7:0]  own_address;
    logic        listening;
    logic [7:0]  pkt_address;
    logic        pkt_toggle;
    logic [7:0]  pkt_command;
    logic        boot_ping;
    logic [7:0]  pkt_length;
    logic [15:0] staged_enable [NUM_FUNCTIONS];
    t_link       link;
    logic        send_tog;
    logic [15:0] leds;

    t_out_item   expected_replies [$];

    int unsigned items_handled   = 0;
    int unsigned replies_checked = 0;
    int unsigned entries_seen    = 0;
    int unsigned reboots_seen    = 0;
    int unsigned address_writes  = 0;
    int unsigned mismatches      = 0;
    int unsigned cycle_count     = 0;
    int unsigned hold_requests   = 0;
    int unsigned holds_served    = 0;
    int unsigned hold_left       = 0;
    logic        steady          = 1'b0;

    function automatic void reset_receiver_state();
        own_address = 8'h00;
        listening   = 1'b0;
        pkt_address = 8'h00;
        pkt_toggle  = 1'b0;
        pkt_command = 8'h00;
        boot_ping   = 1'b0;
        pkt_length  = 8'h00;
        foreach (staged_enable[i]) staged_enable[i] = '0;
        link        = LS_CFG;
        send_tog    = 1'b0;
        leds        = '0;
    endfunction

    task automatic predict_replies(input t_in_item it);
        t_out_item   r;
        t_msg        kind;
        logic        ackd;
        logic        nk;
        logic        cancel;
        logic        apply;
        logic        boot;
        logic [3:0]  ch;
        logic [3:0]  fn;
        int unsigned hdr;
        int          n_res;
        kind   = MSG_NONE;
        ackd   = 1'b0;
        nk     = 1'b0;
        cancel = 1'b0;
        apply  = 1'b0;
        boot   = 1'b0;
        case (it.action)
            ACT_START: begin
                items_handled++;
                pkt_address = it.packet_address;
                pkt_toggle  = it.packet_toggle;
                listening   = (it.packet_address == own_address) ||
                              ((it.packet_address & BCAST_MASK) == BCAST_MASK);
                boot_ping   = (it.packet_length == 8'd3);
                pkt_length  = it.packet_length;
                return;
            end
            ACT_BYTE: begin
                if (listening) begin
                    items_handled++;
                    if (it.byte_position == 8'd0) begin
                        pkt_command = it.payload_byte;
                        if (it.payload_byte != CMD_PING) boot_ping = 1'b0;
                        if (it.payload_byte == CMD_CFG_A || it.payload_byte == CMD_CFG_B) begin
                            foreach (staged_enable[i]) staged_enable[i] = '0;
                        end
                    end else begin
                        if (boot_ping &&
                            ((it.byte_position == 8'd1 && it.payload_byte != CHR_B) ||
                             (it.byte_position == 8'd2 && it.payload_byte != CHR_L))) begin
                            boot_ping = 1'b0;
                        end
                        if (pkt_command == CMD_CFG_A || pkt_command == CMD_CFG_B) begin
                            hdr = (pkt_command == CMD_CFG_B) ? CFG_B_HEADER : CFG_A_HEADER;
                            ch  = it.payload_byte[7:4];
                            fn  = it.payload_byte[3:0];
                            if (it.byte_position > hdr && fn < NUM_FUNCTIONS &&
                                ch < NUM_CHANNELS) begin
                                staged_enable[fn][ch] = 1'b1;
                            end
                        end
                    end
                end
                return;
            end
            ACT_SENT: begin
                items_handled++;
                link = LS_ACK;
            end
            ACT_TIMEOUT: begin
                items_handled++;
                if (link == LS_ACK) nk = 1'b1;
            end
            ACT_END: begin
                items_handled++;
                if (listening && it.crc_ok) begin
                    if ((pkt_address & BCAST_MASK) == BCAST_MASK) begin
                        boot = (pkt_command == CMD_BOOT);
                    end else if (boot_ping) begin
                        boot = 1'b1;
                    end else if (pkt_command == CMD_ACK) begin
                        if (link == LS_ACK) begin
                            link     = LS_IDLE;
                            send_tog = ~send_tog;
                            cancel   = 1'b1;
                            ackd     = 1'b1;
                        end
                    end else if (pkt_command == CMD_PING) begin
                        kind = MSG_PING;
                    end else if (pkt_command == CMD_CFG_A || pkt_command == CMD_CFG_B) begin
                        apply = 1'b1;
                        if (link == LS_CFG) begin
                            link   = LS_IDLE;
                            cancel = 1'b1;
                        end
                    end else if (pkt_command == CMD_BOOT) begin
                        boot = (pkt_length == 8'd1);
                    end else begin
                        ch = pkt_command[7:4];
                        fn = pkt_command[3:0];
                        if (it.repeated) begin
                            fn   = '0;
                            kind = MSG_STATE;
                        end
                        if (fn == FN_LED_ON) begin
                            leds = (ch < NUM_CHANNELS) ? (16'd1 << ch) : 16'd0;
                            kind = MSG_STATE;
                        end else if (fn == FN_LED_OFF) begin
                            leds = '0;
                            kind = MSG_STATE;
                        end
                    end
                    // a reboot request carries nothing else and changes no state
                    if (boot) begin
                        r             = '0;
                        r.reboot      = 1'b1;
                        r.led_mask    = leds;
                        r.send_toggle = send_tog;
                        r.last        = 1'b1;
                        expected_replies.push_back(r);
                        return;
                    end
                    if (link == LS_ACK) begin
                        link   = LS_IDLE;
                        nk     = 1'b1;
                        cancel = 1'b1;
                    end
                end
            end
            default: begin
                return;
            end
        endcase
        n_res = apply ? NUM_FUNCTIONS : 1;
        for (int k = 0; k < n_res; k++) begin
            r = '0;
            if (apply) begin
                r.config_entry   = 1'b1;
                r.function_index = 4'(k);
                r.channel_mask   = staged_enable[k];
            end
            if (k == n_res - 1) begin
                r.message_kind   = kind;
                r.message_toggle = (kind != MSG_NONE) ? pkt_toggle : 1'b0;
                r.ack_done       = ackd;
                r.nack           = nk;
                r.cancel_timer   = cancel;
                r.last           = 1'b1;
            end
            r.led_mask    = leds;
            r.send_toggle = send_tog;
            expected_replies.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_reply(input t_out_item got);
        t_out_item want;
        if (expected_replies.size() == 0) begin
            $error("result transfer with no expected result pending");
            mismatches++;
            return;
        end
        want = expected_replies.pop_front();
        replies_checked++;
        if (got.config_entry === 1'b1) entries_seen++;
        if (got.reboot === 1'b1) reboots_seen++;
        check_field("reboot", want.reboot, got.reboot);
        check_field("message_kind", want.message_kind, got.message_kind);
        check_field("message_toggle", want.message_toggle, got.message_toggle);
        check_field("ack_done", want.ack_done, got.ack_done);
        check_field("nack", want.nack, got.nack);
        check_field("cancel_timer", want.cancel_timer, got.cancel_timer);
        check_field("config_entry", want.config_entry, got.config_entry);
        check_field("function_index", want.function_index, got.function_index);
        check_field("channel_mask", want.channel_mask, got.channel_mask);
        check_field("led_mask", want.led_mask, got.led_mask);
        check_field("send_toggle", want.send_toggle, got.send_toggle);
        check_field("last", want.last, got.last);
    endtask

    // results are checked before the same edge's input transfer is predicted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) check_reply(o_out_data);
            if (i_in_valid && !o_in_stall) predict_replies(i_in_data);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            i_out_stall  <= 1'b1;
        end else begin
            i_out_stall <= !steady && ($urandom_range(99) < 21);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_in_item noise_item();
        t_in_item it;
        it.action         = 3'($urandom);
        it.packet_address = 8'($urandom);
        it.packet_toggle  = 1'($urandom);
        it.packet_length  = 8'($urandom);
        it.byte_position  = 8'($urandom);
        it.payload_byte   = 8'($urandom);
        it.crc_ok         = 1'($urandom);
        it.repeated       = 1'($urandom);
        return it;
    endfunction

    function automatic t_in_item bare_item(input logic [2:0] act);
        t_in_item it;
        it        = noise_item();
        it.action = act;
        return it;
    endfunction

    function automatic t_in_item start_item(input logic [7:0] addr, input logic tog,
                                            input logic [7:0] len);
        t_in_item it;
        it                = bare_item(ACT_START);
        it.packet_address = addr;
        it.packet_toggle  = tog;
        it.packet_length  = len;
        return it;
    endfunction

    function automatic t_in_item byte_item(input logic [7:0] pos, input logic [7:0] b);
        t_in_item it;
        it               = bare_item(ACT_BYTE);
        it.byte_position = pos;
        it.payload_byte  = b;
        return it;
    endfunction

    function automatic t_in_item end_item(input logic crc, input logic rep);
        t_in_item it;
        it          = bare_item(ACT_END);
        it.crc_ok   = crc;
        it.repeated = rep;
        return it;
    endfunction

    task automatic offer(input t_in_item it);
        if (!steady && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_module_address(input logic [7:0] a);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= a;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        own_address = a;
        address_writes++;
    endtask

    task automatic send_packet(input logic [7:0] addr, input logic tog, input logic [7:0] len,
                               input logic [7:0] body [$], input logic crc, input logic rep,
                               input logic mangle);
        logic [7:0] pos;
        offer(start_item(addr, tog, len));
        foreach (body[i]) begin
            pos = 8'(i);
            if (mangle && $urandom_range(3) == 0) pos = 8'($urandom);
            offer(byte_item(pos, body[i]));
        end
        if (!mangle || $urandom_range(2) != 0) offer(end_item(crc, rep));
    endtask

    task automatic send_random_packet();
        logic [7:0]  body [$];
        logic [7:0]  addr;
        logic [7:0]  len;
        int unsigned pick;
        pick = $urandom_range(99);
        body = {};
        if ($urandom_range(99) < 25) offer(bare_item(ACT_SENT));
        if ($urandom_range(99) < 6) offer(noise_item());
        if (pick < 12) begin
            body.push_back(CMD_PING);
            repeat ($urandom_range(2)) body.push_back(8'($urandom));
        end else if (pick < 22) begin
            body = {CMD_PING, CHR_B, CHR_L};
            if ($urandom_range(3) == 0) body[$urandom_range(2)] = 8'($urandom);
        end else if (pick < 34) begin
            body.push_back(CMD_ACK);
            repeat ($urandom_range(1)) body.push_back(8'($urandom));
        end else if (pick < 52) begin
            body.push_back({4'($urandom), ($urandom_range(1) != 0) ? FN_LED_ON : FN_LED_OFF});
            repeat ($urandom_range(1)) body.push_back(8'($urandom));
        end else if (pick < 70) begin
            body.push_back(($urandom_range(1) != 0) ? CMD_CFG_A : CMD_CFG_B);
            repeat ((body[0] == CMD_CFG_B) ? CFG_B_HEADER : CFG_A_HEADER)
                body.push_back(8'($urandom));
            repeat ($urandom_range(8)) begin
                body.push_back({4'($urandom), ($urandom_range(7) == 0) ?
                                4'($urandom) : 4'($urandom_range(NUM_FUNCTIONS - 1))});
            end
        end else if (pick < 80) begin
            body.push_back(CMD_BOOT);
            if ($urandom_range(3) == 0) body.push_back(8'($urandom));
        end else begin
            body.push_back(8'($urandom));
            repeat ($urandom_range(3)) body.push_back(8'($urandom));
        end
        case ($urandom_range(9))
            0, 1:    addr = {3'b111, 5'($urandom)};
            2, 3:    addr = 8'($urandom);
            default: addr = own_address;
        endcase
        if (body[0] == CMD_BOOT && $urandom_range(1) == 0) addr = {3'b111, 5'($urandom)};
        len = 8'(body.size());
        if ($urandom_range(9) == 0) len = 8'($urandom);
        send_packet(addr, 1'($urandom), len, body, $urandom_range(9) != 0,
                    $urandom_range(4) == 0, $urandom_range(11) == 0);
        if ($urandom_range(99) < 10) offer(bare_item(ACT_TIMEOUT));
        if ($urandom_range(99) < 3) wait_drained();
    endtask

    task automatic run_traffic(input int unsigned n);
        int unsigned goal;
        goal = items_handled + n;
        while (items_handled < goal) send_random_packet();
    endtask

    task automatic test_unlistened_items();
        offer(byte_item(8'd0, CMD_CFG_A));
        offer(end_item(1'b1, 1'b0));
        offer(bare_item(ACT_UNUSED_LO));
        offer(bare_item(ACT_UNUSED_HI));
        offer(bare_item(ACT_TIMEOUT));
        wait_drained();
    endtask

    task automatic test_config_staging();
        logic [7:0] body [$];
        body = {CMD_CFG_A, 8'h11, 8'h22, 8'h33, 8'hF6, 8'h07, 8'h30};
        send_packet(own_address, 1'b0, 8'd7, body, 1'b1, 1'b0, 1'b0);
        wait_drained();
    endtask

    task automatic test_link_handshake();
        logic [7:0] body [$];
        offer(bare_item(ACT_SENT));
        body = {CMD_PING};
        send_packet(own_address, 1'b1, 8'd1, body, 1'b1, 1'b0, 1'b0);
        offer(bare_item(ACT_SENT));
        offer(bare_item(ACT_TIMEOUT));
        body = {CMD_ACK};
        send_packet(own_address, 1'b0, 8'd1, body, 1'b1, 1'b0, 1'b0);
        wait_drained();
    endtask

    task automatic test_reboot_requests();
        logic [7:0] body [$];
        body = {CMD_PING, CHR_B, CHR_L};
        send_packet(own_address, 1'b0, 8'd3, body, 1'b1, 1'b0, 1'b0);
        body = {CMD_BOOT};
        send_packet(8'hFF, 1'b1, 8'd1, body, 1'b1, 1'b1, 1'b0);
        wait_drained();
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        run_traffic(60);
        steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_output_holdoff();
        hold_requests++;
        run_traffic(40);
        wait_drained();
    endtask

    task automatic test_address_sweep();
        logic [7:0] settings [4];
        settings = '{8'hFF, 8'h00, 8'($urandom_range(8'hDE, 1)), 8'hDF};
        foreach (settings[i]) begin
            write_module_address(settings[i]);
            run_traffic(70);
        end
    endtask

    task automatic test_mixed_traffic();
        write_module_address(8'($urandom));
        run_traffic(80);
        wait_drained();
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        reset_receiver_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unlistened_items();
        test_config_staging();
        test_link_handshake();
        test_reboot_requests();
        test_steady_stream();
        test_output_holdoff();
        test_address_sweep();
        test_mixed_traffic();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (expected_replies.size() != 0) mismatches++;

        $display("covered %0d handled input transfers and %0d result transfers",
                 items_handled, replies_checked);
        $display("%0d enable table entries, %0d reboot requests, %0d address settings",
                 entries_seen, reboots_seen, address_writes);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
